FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define WSFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising clk edge, reset included.
`define WSFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/wsfr_pkg.sv
// Types, codes and constants shared by the WebSocket frame receiver modules.
package wsfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 64;
    localparam int MSG_W       = 32;
    localparam int KEY_W       = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [MSG_W-1:0] MAX_MSG_RESET = 32'd33554432;

    // Frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_EMPTY_END = 3'd1,
        KIND_PONG_REQ  = 3'd2,
        KIND_UNMASKED  = 3'd3,
        KIND_TOO_LONG  = 3'd4,
        KIND_CLOSED    = 3'd5
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_MESSAGE_BYTES = 1'b0,
        REG_CLIENT_SIDE       = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [MSG_W-1:0] max_message_bytes;
        logic             client_side;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [1:0]        opcode;
        logic              last;
    } result_t;

endpackage

FILE: hw/rtl/wsfr_cfg_regs.sv
// Configuration register file: message length limit and client-side flag.
module wsfr_cfg_regs
    import wsfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [MSG_W-1:0]       cfg_data,
    output cfg_t                   cfg
);

    logic [MSG_W-1:0] max_bytes_reg;
    logic             client_side_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg   <= MAX_MSG_RESET;
            client_side_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_MESSAGE_BYTES: max_bytes_reg   <= cfg_data;
                REG_CLIENT_SIDE:       client_side_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    assign cfg.max_message_bytes = max_bytes_reg;
    assign cfg.client_side       = client_side_reg;

endmodule

FILE: hw/rtl/wsfr_in_reg.sv
// Input register: holds one received byte until the parser takes it.
module wsfr_in_reg
    import wsfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              take,
    output logic              held_valid,
    output logic [BYTE_W-1:0] held_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // Refill in the same cycle the held byte moves on
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= rx_byte;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

FILE: hw/rtl/wsfr_parser.sv
// Frame parser: header, extended length, mask key and payload state per byte.
module wsfr_parser
    import wsfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] byte_in,
    input  cfg_t              cfg,
    output result_t           result
);

    phase_t            phase_reg, phase_next;
    logic              fin_reg, fin_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic              masked_reg, masked_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [1:0]        idx_reg, idx_next;
    logic [2:0]        hcount_reg, hcount_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [MSG_W-1:0]  msg_len_reg, msg_len_next;
    logic [1:0]        held_reg, held_next;
    logic              dead_reg, dead_next;

    logic [3:0]        hdr_op;
    logic              hdr_bad;
    logic              frame_is_data;
    logic [6:0]        len7;
    logic              len_ext;
    logic              unmasked_err;
    logic [LEN_W-1:0]  ext_shift;
    logic [LEN_W-1:0]  lk_len;
    logic              lk_masked;
    logic [MSG_W:0]    lk_add;
    logic [MSG_W-1:0]  lk_sum;
    logic              lk_too_long;
    logic              lk_empty_end;
    logic              do_lk;
    phase_t            lk_phase;
    logic [LEN_W-1:0]  rem_dec;
    logic              rem_last;
    logic              key_empty_end;
    logic [BYTE_W-1:0] key_byte;

    assign hdr_op        = byte_in[3:0];
    assign hdr_bad       = (hdr_op > OP_BINARY) && (hdr_op != OP_PING) && (hdr_op != OP_PONG);
    assign frame_is_data = opcode_reg <= OP_BINARY;
    assign len7          = byte_in[6:0];
    assign len_ext       = (len7 == LEN7_EXT16) || (len7 == LEN7_EXT64);
    assign unmasked_err  = frame_is_data && !cfg.client_side && !byte_in[7];
    assign ext_shift     = {rem_reg[LEN_W-BYTE_W-1:0], byte_in};

    // Frame length is known after the short length or the last extended byte
    assign lk_len    = (phase_reg == PH_HDR1) ? {{(LEN_W-7){1'b0}}, len7} : ext_shift;
    assign lk_masked = (phase_reg == PH_HDR1) ? byte_in[7] : masked_reg;
    assign lk_add    = {1'b0, msg_len_reg} + {1'b0, lk_len[MSG_W-1:0]};
    assign lk_sum    = ((|lk_len[LEN_W-1:MSG_W]) || lk_add[MSG_W]) ? '1 : lk_add[MSG_W-1:0];
    assign lk_too_long  = frame_is_data && (lk_sum >= cfg.max_message_bytes);
    assign lk_empty_end = frame_is_data && fin_reg && (lk_len == '0);
    assign do_lk = ((phase_reg == PH_HDR1) && !unmasked_err && !len_ext)
                || ((phase_reg == PH_EXTLEN) && (hcount_reg == 3'd0));
    assign lk_phase = lk_too_long ? phase_reg
                    : lk_masked ? PH_KEY
                    : (lk_len != '0) ? PH_PAYLOAD : PH_HDR0;

    assign rem_dec       = rem_reg - {{(LEN_W-1){1'b0}}, 1'b1};
    assign rem_last      = rem_dec == '0;
    assign key_empty_end = frame_is_data && fin_reg && (rem_reg == '0);
    assign key_byte      = masked_reg ? key_reg[{~idx_reg, 3'b000} +: BYTE_W] : '0;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (!dead_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                    if (!hdr_bad)
                        phase_next = PH_HDR1;
                PH_HDR1:
                    if (!unmasked_err)
                        phase_next = len_ext ? PH_EXTLEN : lk_phase;
                PH_EXTLEN:
                    if (hcount_reg == 3'd0)
                        phase_next = lk_phase;
                PH_KEY:
                    if (hcount_reg == 3'd0)
                        phase_next = (rem_reg != '0) ? PH_PAYLOAD : PH_HDR0;
                PH_PAYLOAD:
                    if (rem_last)
                        phase_next = PH_HDR0;
                default:
                    phase_next = PH_HDR0;
            endcase
        end
    end

    // Frame state and result
    always_comb
    begin
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        masked_next  = masked_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        hcount_next  = hcount_reg;
        rem_next     = rem_reg;
        msg_len_next = msg_len_reg;
        held_next    = held_reg;
        dead_next    = dead_reg;
        result        = '0;
        result.kind   = KIND_DATA;
        result.opcode = held_reg;

        if (!dead_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    fin_next    = byte_in[7];
                    opcode_next = hdr_op;
                    if (hdr_bad)
                    begin
                        dead_next    = 1'b1;
                        result.valid = 1'b1;
                        result.kind  = KIND_CLOSED;
                    end
                    else if (((hdr_op == OP_TEXT) || (hdr_op == OP_BINARY)) && (held_reg == 2'd0))
                        held_next = hdr_op[1:0];
                end
                PH_HDR1:
                begin
                    masked_next = byte_in[7];
                    if (unmasked_err)
                    begin
                        dead_next    = 1'b1;
                        result.valid = 1'b1;
                        result.kind  = KIND_UNMASKED;
                    end
                    else if (len7 == LEN7_EXT16)
                    begin
                        rem_next    = '0;
                        hcount_next = 3'd1;
                    end
                    else if (len7 == LEN7_EXT64)
                    begin
                        rem_next    = '0;
                        hcount_next = 3'd7;
                    end
                    else
                        rem_next = lk_len;
                end
                PH_EXTLEN:
                begin
                    rem_next = ext_shift;
                    if (hcount_reg != 3'd0)
                        hcount_next = hcount_reg - 3'd1;
                end
                PH_KEY:
                begin
                    key_next = {key_reg[KEY_W-BYTE_W-1:0], byte_in};
                    if (hcount_reg == 3'd0)
                    begin
                        idx_next = 2'd0;
                        if (key_empty_end)
                        begin
                            result.valid = 1'b1;
                            result.kind  = KIND_EMPTY_END;
                            result.last  = 1'b1;
                            msg_len_next = '0;
                            held_next    = 2'd0;
                        end
                    end
                    else
                        hcount_next = hcount_reg - 3'd1;
                end
                PH_PAYLOAD:
                begin
                    idx_next = idx_reg + 2'd1;
                    rem_next = rem_dec;
                    if (frame_is_data)
                    begin
                        result.valid = 1'b1;
                        result.kind  = KIND_DATA;
                        result.data  = byte_in ^ key_byte;
                        result.last  = rem_last && fin_reg;
                        if (rem_last && fin_reg)
                        begin
                            msg_len_next = '0;
                            held_next    = 2'd0;
                        end
                    end
                end
                default: ;
            endcase

            // Length check, then mask key or payload
            if (do_lk)
            begin
                if (lk_too_long)
                begin
                    dead_next    = 1'b1;
                    result.valid = 1'b1;
                    result.kind  = KIND_TOO_LONG;
                end
                else
                begin
                    if (frame_is_data)
                        msg_len_next = lk_sum;
                    if (lk_masked)
                    begin
                        hcount_next = 3'd3;
                        key_next    = '0;
                    end
                    else
                    begin
                        idx_next = 2'd0;
                        if (lk_empty_end)
                        begin
                            result.valid = 1'b1;
                            result.kind  = KIND_EMPTY_END;
                            result.last  = 1'b1;
                            msg_len_next = '0;
                            held_next    = 2'd0;
                        end
                    end
                end
            end

            // A ping raises a pong request at its second header byte
            if ((phase_reg == PH_HDR1) && (opcode_reg == OP_PING))
            begin
                result.valid = 1'b1;
                result.kind  = KIND_PONG_REQ;
                result.data  = '0;
                result.last  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            fin_reg     <= 1'b0;
            opcode_reg  <= OP_CONT;
            masked_reg  <= 1'b0;
            key_reg     <= '0;
            idx_reg     <= 2'd0;
            hcount_reg  <= 3'd0;
            rem_reg     <= '0;
            msg_len_reg <= '0;
            held_reg    <= 2'd0;
            dead_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            masked_reg  <= masked_next;
            key_reg     <= key_next;
            idx_reg     <= idx_next;
            hcount_reg  <= hcount_next;
            rem_reg     <= rem_next;
            msg_len_reg <= msg_len_next;
            held_reg    <= held_next;
            dead_reg    <= dead_next;
        end
    end

endmodule

FILE: hw/rtl/wsfr_out_reg.sv
// Result register: holds one result until the downstream side takes it.
module wsfr_out_reg
    import wsfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  result_t           result,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              free,
    output logic [2:0]        kind,
    output logic [BYTE_W-1:0] payload_byte,
    output logic [1:0]        message_opcode,
    output logic              last
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign out_valid      = valid_reg;
    assign kind           = data_reg.kind;
    assign payload_byte   = data_reg.data;
    assign message_opcode = data_reg.opcode;
    assign last           = data_reg.last;

endmodule

FILE: hw/rtl/websocket_frame_receiver.sv
// WebSocket frame receiver top level: byte input, result output, config port.
//
// Usage:
// - Input channel (in_valid / in_ready / rx_byte) carries the received stream,
//   one byte per request. Output channel (out_valid / out_ready) carries at
//   most one result per byte: kind, payload_byte, message_opcode, last.
// - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   register 0 (max_message_bytes) or register 1 (client_side, bit 0).
//   cfg_ready is always high; write only while the block is idle.
// - Throughput: one byte per cycle, sustained while the result register is
//   free. The per-byte state update is a single pass between the input
//   register and the result register; the widest path is the 33-bit
//   saturating length add and compare; a result loads as its byte advances.
// - Reset clears the parser to "expect first header byte", restores the
//   register defaults and empties both holding registers.
// - When the receiver stalls, the result register holds its request; bytes
//   that produce no result keep flowing, and one more byte is held in the
//   input register before in_ready drops.
// - After an error result (unmasked, too long, closed) no further results
//   are produced until reset; input is still accepted and dropped.
module websocket_frame_receiver
    import wsfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             kind,
    output logic [BYTE_W-1:0]      payload_byte,
    output logic [1:0]             message_opcode,
    output logic                   last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [MSG_W-1:0]       cfg_data
);

    cfg_t              cfg;
    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              out_free;
    logic              advance;
    result_t           result;

    // Advance the held byte when its result has a place to go, or when it
    // has no result at all
    assign advance = held_valid && (out_free || !result.valid);

    wsfr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wsfr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .take       (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    wsfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (held_byte),
        .cfg     (cfg),
        .result  (result)
    );

    // Load a result only when the byte actually advances
    wsfr_out_reg u_out_reg (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (advance && result.valid),
        .result         (result),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .free           (out_free),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .message_opcode (message_opcode),
        .last           (last)
    );

endmodule

FILE: hw/rtl/wsfr_checker.sv
// Port-level checker for the WebSocket frame receiver, bound to the top level.
`include "assert_macros.svh"

module wsfr_checker
    import wsfr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [2:0]             kind,
    input logic [BYTE_W-1:0]      payload_byte,
    input logic [1:0]             message_opcode,
    input logic                   last
);

    // No request may be offered while reset is held
    `WSFR_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !out_valid, "result valid during reset")

    // A stalled result keeps its request
    `WSFR_ASSERT(a_result_holds, out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte) && $stable(message_opcode) && $stable(last), "stalled result changed")

    // Only payload bytes and empty message ends close a message
    `WSFR_ASSERT(a_last_kind, out_valid && last |-> (kind == KIND_DATA || kind == KIND_EMPTY_END), "last set on a non-data result")

    // Non-data results carry a zero byte
    `WSFR_ASSERT(a_zero_byte, out_valid && (kind != KIND_DATA) |-> (payload_byte == '0), "byte set on a non-data result")

    // An error ends all output until reset
    `WSFR_ASSERT(a_dead_after_error, out_valid && out_ready && (kind >= KIND_UNMASKED) |=> !out_valid, "result after an error")

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (.*);
